// File: hw/rtl/fslc_pkg.sv
// ----------------------------------------------------------------------------
// fslc_pkg
// Types and constants shared by the focus session lock controller.
// ----------------------------------------------------------------------------
`default_nettype none

package fslc_pkg;

    typedef enum logic [3:0] {
        CMD_START   = 4'd0,
        CMD_URGENT  = 4'd1,
        CMD_RESPOND = 4'd2,
        CMD_RESUME  = 4'd3,
        CMD_END     = 4'd4,
        CMD_PAUSE   = 4'd5,
        CMD_BUTTON  = 4'd6,
        CMD_TIMEOUT = 4'd7,
        CMD_TICK    = 4'd8
    } cmd_t;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_LOCKED = 3'd1,
        MODE_URGENT = 3'd2,
        MODE_RESUME = 3'd3,
        MODE_DONE   = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        SCR_NONE      = 3'd0,
        SCR_COUNTDOWN = 3'd1,
        SCR_PROMPT    = 3'd2,
        SCR_END       = 3'd3,
        SCR_TIMESUP   = 3'd4,
        SCR_URGENT    = 3'd5
    } screen_t;

    localparam logic [1:0] BTN_NONE = 2'd0;
    localparam logic [1:0] BTN_YES  = 2'd1;
    localparam logic [1:0] BTN_NO   = 2'd2;

    localparam logic CFG_MAX_MIN  = 1'b0;
    localparam logic CFG_DEBOUNCE = 1'b1;

    localparam logic [9:0]  MAX_MIN_RST  = 10'd180;
    localparam logic [15:0] DEBOUNCE_RST = 16'd200;

    localparam int REM_W = 23;
    localparam int SECS_W = 13;
    // largest shown time in ms that still divides to 5999 seconds
    localparam logic [REM_W-1:0] REM_CLAMP_MS = 23'd5999999;
    // reciprocal of 1000 with a 33-bit shift, exact for values below 2^23
    localparam logic [23:0] RECIP_1000 = 24'd8589935;
    // reciprocal of 60 with a 20-bit shift, exact for values below 2^14
    localparam logic [14:0] RECIP_60 = 15'd17477;

    typedef struct packed {
        cmd_t        command;
        logic [31:0] now_ms;
        logic [19:0] arg_value;
        logic        arg_yes;
        logic        arg_has_secs;
        logic [1:0]  button;
    } evt_t;

    typedef struct packed {
        mode_t            mode;
        logic             lock;
        screen_t          screen;
        logic [REM_W-1:0] rem_ms;
    } stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/fslc_if.sv
// ----------------------------------------------------------------------------
// fslc_evt_if / fslc_stat_if
// Valid/ready channels for event beats and status beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface fslc_evt_if;
    logic        valid;
    logic        ready;
    logic [3:0]  command;
    logic [31:0] now_ms;
    logic [19:0] arg_value;
    logic        arg_yes;
    logic        arg_has_secs;
    logic [1:0]  button;

    modport source (output valid, command, now_ms, arg_value, arg_yes, arg_has_secs, button,
                    input ready);
    modport sink (input valid, command, now_ms, arg_value, arg_yes, arg_has_secs, button,
                  output ready);
endinterface

interface fslc_stat_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode_code;
    logic [6:0] remain_minutes;
    logic [5:0] remain_seconds;
    logic       lock_engaged;
    logic [2:0] screen;

    modport source (output valid, mode_code, remain_minutes, remain_seconds, lock_engaged,
                    screen, input ready);
    modport sink (input valid, mode_code, remain_minutes, remain_seconds, lock_engaged,
                  screen, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/fslc_core.sv
// ----------------------------------------------------------------------------
// fslc_core
// Event register, session state, configuration and one-pass state update.
// ----------------------------------------------------------------------------
`default_nettype none

module fslc_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_we,
    input  wire logic            cfg_index,
    input  wire logic [15:0]     cfg_data,
    fslc_evt_if.sink             evt,
    output fslc_pkg::stat_t      st,
    output logic                 st_valid,
    input  wire logic            st_ready
);

    logic [9:0]  max_min_reg;
    logic [15:0] debounce_reg;

    logic            s1_v_reg;
    fslc_pkg::evt_t  s1_reg;
    logic            s2_v_reg;
    fslc_pkg::stat_t s2_reg;

    fslc_pkg::mode_t mode_reg, mode_next;
    logic [31:0]     end_reg, end_next;
    logic [31:0]     resume_reg, resume_next;
    logic [31:0]     press_reg, press_next;
    logic            lock_reg, lock_next;

    fslc_pkg::screen_t scr;
    logic              res;
    logic [31:0]       d;
    logic [31:0]       left;
    logic [31:0]       prod60k;
    logic [31:0]       prod1k;
    logic [15:0]       max_secs;
    logic [31:0]       r;
    logic [31:0]       rem_raw;
    logic [fslc_pkg::REM_W-1:0] rem_ms;
    logic              s2_open;
    logic              s1_go;

    assign s2_open   = !s2_v_reg || st_ready;
    assign s1_go     = s1_v_reg && s2_open;
    assign evt.ready = !s1_v_reg || s2_open;
    assign st        = s2_reg;
    assign st_valid  = s2_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_min_reg  <= fslc_pkg::MAX_MIN_RST;
            debounce_reg <= fslc_pkg::DEBOUNCE_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == fslc_pkg::CFG_MAX_MIN)
                max_min_reg <= cfg_data[9:0];
            else
                debounce_reg <= cfg_data;
        end
    end

    always_comb
    begin
        prod60k  = 32'(s1_reg.arg_value[9:0]) * 32'd60000;
        prod1k   = 32'(s1_reg.arg_value) * 32'd1000;
        max_secs = 16'(max_min_reg) * 16'd60;
        left     = (end_reg > s1_reg.now_ms) ? (end_reg - s1_reg.now_ms) : 32'd0;
        d        = end_reg - s1_reg.now_ms;
        r        = resume_reg;

        mode_next   = mode_reg;
        end_next    = end_reg;
        resume_next = resume_reg;
        press_next  = press_reg;
        lock_next   = lock_reg;
        scr         = fslc_pkg::SCR_NONE;
        res         = 1'b1;

        unique case (s1_reg.command)
            fslc_pkg::CMD_START:
            begin
                if (s1_reg.arg_value != 20'd0 && s1_reg.arg_value <= 20'(max_min_reg))
                begin
                    end_next  = s1_reg.now_ms + prod60k;
                    d         = prod60k;
                    mode_next = fslc_pkg::MODE_LOCKED;
                    lock_next = 1'b1;
                    scr       = fslc_pkg::SCR_COUNTDOWN;
                end
            end
            fslc_pkg::CMD_URGENT:
            begin
                if (mode_reg == fslc_pkg::MODE_LOCKED)
                begin
                    mode_next = fslc_pkg::MODE_URGENT;
                    scr       = fslc_pkg::SCR_URGENT;
                end
            end
            fslc_pkg::CMD_RESPOND:
            begin
                if (mode_reg == fslc_pkg::MODE_URGENT)
                begin
                    if (s1_reg.arg_yes)
                    begin
                        resume_next = left;
                        lock_next   = 1'b0;
                        mode_next   = fslc_pkg::MODE_RESUME;
                        scr         = fslc_pkg::SCR_PROMPT;
                    end
                    else
                    begin
                        mode_next = fslc_pkg::MODE_LOCKED;
                        scr       = fslc_pkg::SCR_COUNTDOWN;
                    end
                end
            end
            fslc_pkg::CMD_RESUME:
            begin
                if (s1_reg.arg_yes)
                begin
                    if (s1_reg.arg_has_secs && s1_reg.arg_value != 20'd0
                        && s1_reg.arg_value <= 20'(max_secs))
                        r = prod1k;
                    resume_next = r;
                    end_next    = s1_reg.now_ms + r;
                    d           = r;
                    lock_next   = 1'b1;
                    mode_next   = fslc_pkg::MODE_LOCKED;
                    scr         = fslc_pkg::SCR_COUNTDOWN;
                end
                else
                begin
                    mode_next = fslc_pkg::MODE_DONE;
                    lock_next = 1'b0;
                    scr       = fslc_pkg::SCR_END;
                end
            end
            fslc_pkg::CMD_END:
            begin
                mode_next = fslc_pkg::MODE_DONE;
                lock_next = 1'b0;
                scr       = fslc_pkg::SCR_END;
            end
            fslc_pkg::CMD_PAUSE:
            begin
                if (mode_reg == fslc_pkg::MODE_LOCKED || mode_reg == fslc_pkg::MODE_URGENT)
                begin
                    resume_next = (s1_reg.arg_value != 20'd0) ? prod1k : left;
                    lock_next   = 1'b0;
                    mode_next   = fslc_pkg::MODE_RESUME;
                    scr         = fslc_pkg::SCR_PROMPT;
                end
            end
            fslc_pkg::CMD_BUTTON:
            begin
                if (s1_reg.button == fslc_pkg::BTN_NONE
                    || (mode_reg != fslc_pkg::MODE_URGENT && mode_reg != fslc_pkg::MODE_RESUME)
                    || (s1_reg.now_ms - press_reg) <= 32'(debounce_reg))
                    res = 1'b0;
                else
                begin
                    press_next = s1_reg.now_ms;
                    if (mode_reg == fslc_pkg::MODE_URGENT && s1_reg.button == fslc_pkg::BTN_YES)
                    begin
                        resume_next = left;
                        lock_next   = 1'b0;
                        mode_next   = fslc_pkg::MODE_RESUME;
                        scr         = fslc_pkg::SCR_PROMPT;
                    end
                    else if (mode_reg == fslc_pkg::MODE_URGENT
                             && s1_reg.button == fslc_pkg::BTN_NO)
                    begin
                        mode_next = fslc_pkg::MODE_LOCKED;
                        scr       = fslc_pkg::SCR_COUNTDOWN;
                    end
                    else if (mode_reg == fslc_pkg::MODE_RESUME
                             && s1_reg.button == fslc_pkg::BTN_YES)
                    begin
                        end_next  = s1_reg.now_ms + resume_reg;
                        d         = resume_reg;
                        lock_next = 1'b1;
                        mode_next = fslc_pkg::MODE_LOCKED;
                        scr       = fslc_pkg::SCR_COUNTDOWN;
                    end
                    else if (mode_reg == fslc_pkg::MODE_RESUME
                             && s1_reg.button == fslc_pkg::BTN_NO)
                    begin
                        mode_next = fslc_pkg::MODE_DONE;
                        scr       = fslc_pkg::SCR_END;
                    end
                    else
                        res = 1'b0;
                end
            end
            fslc_pkg::CMD_TIMEOUT:
            begin
                if (mode_reg == fslc_pkg::MODE_LOCKED && s1_reg.now_ms >= end_reg)
                begin
                    lock_next = 1'b0;
                    mode_next = fslc_pkg::MODE_DONE;
                    scr       = fslc_pkg::SCR_TIMESUP;
                end
                else
                    res = 1'b0;
            end
            fslc_pkg::CMD_TICK:
            begin
                scr = (mode_reg == fslc_pkg::MODE_LOCKED) ? fslc_pkg::SCR_COUNTDOWN
                                                          : fslc_pkg::SCR_NONE;
            end
            default:
            begin
                res = 1'b0;
            end
        endcase

        if (mode_next == fslc_pkg::MODE_LOCKED || mode_next == fslc_pkg::MODE_URGENT)
            rem_raw = d[31] ? 32'd0 : d;
        else if (mode_next == fslc_pkg::MODE_RESUME)
            rem_raw = resume_next;
        else
            rem_raw = 32'd0;

        if (rem_raw > 32'(fslc_pkg::REM_CLAMP_MS))
            rem_ms = fslc_pkg::REM_CLAMP_MS;
        else
            rem_ms = rem_raw[fslc_pkg::REM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg   <= 1'b0;
            s2_v_reg   <= 1'b0;
            mode_reg   <= fslc_pkg::MODE_IDLE;
            end_reg    <= 32'd0;
            resume_reg <= 32'd0;
            press_reg  <= 32'd0;
            lock_reg   <= 1'b0;
        end
        else
        begin
            if (evt.ready)
                s1_v_reg <= evt.valid;
            if (s2_open)
                s2_v_reg <= s1_v_reg && res;
            if (s1_go)
            begin
                mode_reg   <= mode_next;
                end_reg    <= end_next;
                resume_reg <= resume_next;
                press_reg  <= press_next;
                lock_reg   <= lock_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.valid && evt.ready)
        begin
            s1_reg.command      <= fslc_pkg::cmd_t'(evt.command);
            s1_reg.now_ms       <= evt.now_ms;
            s1_reg.arg_value    <= evt.arg_value;
            s1_reg.arg_yes      <= evt.arg_yes;
            s1_reg.arg_has_secs <= evt.arg_has_secs;
            s1_reg.button       <= evt.button;
        end
        if (s1_go)
        begin
            s2_reg.mode   <= mode_next;
            s2_reg.lock   <= lock_next;
            s2_reg.screen <= scr;
            s2_reg.rem_ms <= rem_ms;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/fslc_fmt.sv
// ----------------------------------------------------------------------------
// fslc_fmt
// Convert remaining milliseconds to clamped minutes and seconds.
// ----------------------------------------------------------------------------
`default_nettype none

module fslc_fmt #(
    parameter int MAX_SHOWN_SECS = 5999
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire fslc_pkg::stat_t st,
    input  wire logic            st_valid,
    output logic                 st_ready,
    fslc_stat_if.source          stat
);

    localparam logic [fslc_pkg::SECS_W-1:0] MaxSecs = fslc_pkg::SECS_W'(MAX_SHOWN_SECS);

    logic                        s3_v_reg;
    fslc_pkg::stat_t             s3_reg;
    logic [fslc_pkg::SECS_W-1:0] secs_reg;
    logic                        o_v_reg;
    logic [2:0]                  mode_reg;
    logic [6:0]                  min_reg;
    logic [5:0]                  sec_reg;
    logic                        lock_reg;
    logic [2:0]                  scr_reg;

    logic [46:0]                 p1000;
    logic [fslc_pkg::SECS_W-1:0] q1000;
    logic [fslc_pkg::SECS_W-1:0] secs;
    logic [27:0]                 p60;
    logic [6:0]                  mins;
    logic [fslc_pkg::SECS_W-1:0] sec_part;
    logic                        s3_open;

    assign s3_open  = !o_v_reg || stat.ready;
    assign st_ready = !s3_v_reg || s3_open;

    always_comb
    begin
        p1000    = 47'(st.rem_ms) * 47'(fslc_pkg::RECIP_1000);
        q1000    = p1000[45:33];
        secs     = (q1000 > MaxSecs) ? MaxSecs : q1000;
        p60      = 28'(secs_reg) * 28'(fslc_pkg::RECIP_60);
        mins     = p60[26:20];
        sec_part = secs_reg - fslc_pkg::SECS_W'(mins) * fslc_pkg::SECS_W'(60);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
        end
        else
        begin
            if (st_ready)
                s3_v_reg <= st_valid;
            if (s3_open)
                o_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_ready && st_valid)
        begin
            s3_reg   <= st;
            secs_reg <= secs;
        end
        if (s3_open && s3_v_reg)
        begin
            mode_reg <= s3_reg.mode;
            min_reg  <= mins;
            sec_reg  <= sec_part[5:0];
            lock_reg <= s3_reg.lock;
            scr_reg  <= s3_reg.screen;
        end
    end

    assign stat.valid          = o_v_reg;
    assign stat.mode_code      = mode_reg;
    assign stat.remain_minutes = min_reg;
    assign stat.remain_seconds = sec_reg;
    assign stat.lock_engaged   = lock_reg;
    assign stat.screen         = scr_reg;

endmodule

`default_nettype wire

// File: hw/rtl/focus_session_lock_controller.sv
// ----------------------------------------------------------------------------
// focus_session_lock_controller
// Timed lock session controller: takes event beats, updates the session
// and returns status beats with mode, remaining time, lock and screen.
//
//   channel  dir  beat
//   evt      in   command, now_ms, arg_value, arg_yes, arg_has_secs, button
//   stat     out  mode_code, remain_minutes, remain_seconds, lock_engaged, screen
//   cfg      in   cfg_we, cfg_index, cfg_data (write only)
//
// One event beat per cycle is taken. The path from evt beat to stat beat
// runs through the event register, state update, divide by 1000 and split
// into minutes and seconds. Session state is written in the state update.
// Reset clears the session and loads the register defaults; no clearing pass.
// Stalls on stat fill the pipeline, then drop evt.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module focus_session_lock_controller #(
    parameter int MAX_SHOWN_SECS = 5999
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    fslc_evt_if.sink         evt,
    fslc_stat_if.source      stat
);

    fslc_pkg::stat_t st;
    logic            st_valid;
    logic            st_ready;

    fslc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .evt       (evt),
        .st        (st),
        .st_valid  (st_valid),
        .st_ready  (st_ready)
    );

    fslc_fmt #(
        .MAX_SHOWN_SECS (MAX_SHOWN_SECS)
    ) u_fmt (
        .clk      (clk),
        .rst_n    (rst_n),
        .st       (st),
        .st_valid (st_valid),
        .st_ready (st_ready),
        .stat     (stat)
    );

`ifndef NO_ASSERTIONS
    a_lock_mode: assert property (@(posedge clk) disable iff (!rst_n)
        stat.valid |-> stat.lock_engaged ==
            (stat.mode_code == fslc_pkg::MODE_LOCKED || stat.mode_code == fslc_pkg::MODE_URGENT))
        else $error("lock level disagrees with mode");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        stat.valid && (stat.mode_code == fslc_pkg::MODE_IDLE
                       || stat.mode_code == fslc_pkg::MODE_DONE)
        |-> stat.remain_minutes == 7'd0 && stat.remain_seconds == 6'd0)
        else $error("remaining time shown outside a session");

    a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
        stat.valid |-> stat.remain_seconds < 6'd60)
        else $error("seconds part out of range");

    a_timesup: assert property (@(posedge clk) disable iff (!rst_n)
        stat.valid && stat.screen == fslc_pkg::SCR_TIMESUP
        |-> stat.mode_code == fslc_pkg::MODE_DONE && !stat.lock_engaged)
        else $error("times up screen without finished session");
`endif

endmodule

`default_nettype wire
